// ===== hw/rtl/tte_pkg.sv =====
// Shared types, constants and microcode store for the tap tempo estimator.
// No dependencies; used by tte_divider and tap_tempo_estimator.

package tte_pkg;

    // Field widths
    localparam int TIME_WIDTH_DEF = 32;
    localparam int THR_W          = 16;
    localparam int SUM_W          = 32;
    localparam int COUNT_W        = 16;
    localparam int STATUS_W       = 2;
    localparam int AVG_US_W       = 26;
    localparam int BPM_W          = 23;
    localparam int OUT_BPM_W      = 30;

    // Register reset value
    localparam logic [THR_W-1:0] THR_RESET = 16'd5000;

    // Scaling constants
    localparam int PROD_US_W  = SUM_W + 10;
    localparam int PROD_BPM_W = COUNT_W + BPM_W;
    localparam logic [9:0]       MS_PER_S     = 10'd1000;
    localparam logic [BPM_W-1:0] BPM_X100_NUM = 23'd6000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    // Divider geometry: quotient bits produced per division
    localparam int DIV_REM_W = 32;
    localparam int DIV_NUM_W = 26;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] ITERS_US  = 5'd26;
    localparam logic [DIV_CNT_W-1:0] ITERS_BPM = 5'd23;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_EST  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EST     = 2'd2;

    // Divider control
    typedef struct packed {
        logic                 start;
        logic                 step;
        logic [DIV_CNT_W-1:0] iters;
    } t_div_ctrl;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_UPDATE,
        OP_LD_AVG_US,
        OP_LD_AVG_BPM,
        OP_LD_LAST,
        OP_DIV_STEP,
        OP_ST_AVG_US,
        OP_ST_AVG_BPM,
        OP_ST_LAST,
        OP_EMIT
    } t_op;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT_IN,
        C_SKIP_NO_EST,
        C_SKIP_NO_LAST,
        C_LOOP_DIV,
        C_WAIT_OUT
    } t_cond;

    localparam int STEP_W = 4;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Program addresses
    localparam logic [STEP_W-1:0] S_ACCEPT     = 4'd0;
    localparam logic [STEP_W-1:0] S_UPDATE     = 4'd1;
    localparam logic [STEP_W-1:0] S_LD_AVG_US  = 4'd2;
    localparam logic [STEP_W-1:0] S_DIV_US     = 4'd3;
    localparam logic [STEP_W-1:0] S_ST_AVG_US  = 4'd4;
    localparam logic [STEP_W-1:0] S_LD_AVG_BPM = 4'd5;
    localparam logic [STEP_W-1:0] S_DIV_BPM    = 4'd6;
    localparam logic [STEP_W-1:0] S_ST_AVG_BPM = 4'd7;
    localparam logic [STEP_W-1:0] S_LD_LAST    = 4'd8;
    localparam logic [STEP_W-1:0] S_DIV_LAST   = 4'd9;
    localparam logic [STEP_W-1:0] S_ST_LAST    = 4'd10;
    localparam logic [STEP_W-1:0] S_EMIT       = 4'd11;

    // Microcode store: one control word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] addr);
        t_uword w;
        case (addr)
            S_ACCEPT:     w = '{OP_ACCEPT,     C_WAIT_IN,      S_ACCEPT};
            S_UPDATE:     w = '{OP_UPDATE,     C_NEXT,         S_ACCEPT};
            S_LD_AVG_US:  w = '{OP_LD_AVG_US,  C_SKIP_NO_EST,  S_EMIT};
            S_DIV_US:     w = '{OP_DIV_STEP,   C_LOOP_DIV,     S_ACCEPT};
            S_ST_AVG_US:  w = '{OP_ST_AVG_US,  C_NEXT,         S_ACCEPT};
            S_LD_AVG_BPM: w = '{OP_LD_AVG_BPM, C_NEXT,         S_ACCEPT};
            S_DIV_BPM:    w = '{OP_DIV_STEP,   C_LOOP_DIV,     S_ACCEPT};
            S_ST_AVG_BPM: w = '{OP_ST_AVG_BPM, C_NEXT,         S_ACCEPT};
            S_LD_LAST:    w = '{OP_LD_LAST,    C_SKIP_NO_LAST, S_EMIT};
            S_DIV_LAST:   w = '{OP_DIV_STEP,   C_LOOP_DIV,     S_ACCEPT};
            S_ST_LAST:    w = '{OP_ST_LAST,    C_NEXT,         S_ACCEPT};
            S_EMIT:       w = '{OP_EMIT,       C_WAIT_OUT,     S_ACCEPT};
            default:      w = '{OP_NOP,        C_GOTO,         S_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/tte_divider.sv =====
// Restoring radix-2 divider, one quotient bit per step, driven by the sequencer.
// Depends on tte_pkg for widths and the control struct.

module tte_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tte_pkg::t_div_ctrl            i_ctrl,
    input  logic [tte_pkg::DIV_REM_W-1:0] i_rem_init,
    input  logic [tte_pkg::DIV_NUM_W-1:0] i_num_init,
    input  logic [tte_pkg::DIV_REM_W-1:0] i_divisor,
    output logic                          o_last,
    output logic [tte_pkg::DIV_NUM_W-1:0] o_quotient
);
    import tte_pkg::*;

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [DIV_REM_W:0] trial;
    logic [DIV_REM_W:0] trial_sub;
    logic               fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial     = {r_rem, r_num[DIV_NUM_W-1]};
        trial_sub = trial - {1'b0, r_div};
        fits      = (trial >= {1'b0, r_div});
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.start) begin
            r_cnt <= i_ctrl.iters;
        end else if (i_ctrl.step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder, dividend bits and quotient
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem  <= i_rem_init;
            r_num  <= i_num_init;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (i_ctrl.step) begin
            r_rem  <= fits ? trial_sub[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_NUM_W-2:0], fits};
        end
    end

    assign o_last     = (r_cnt == DIV_CNT_W'(1));
    assign o_quotient = r_quot;

endmodule

// ===== hw/rtl/tap_tempo_estimator.sv =====
// Tap tempo estimator: a microcoded sequencer steps a small datapath and a shared divider.
// Items without an estimate skip the divisions; with one, the two average divisions run,
// and the last-interval division only for a positive interval; one quotient bit per cycle.
// The result is registered and shows the cycle after the emit step; the next item is
// taken while it waits. Synchronous active-low reset clears sum, count, last tap time
// and the output valid, and sets the threshold to 5000 ms. Depends on tte_pkg, tte_divider.

module tap_tempo_estimator #(
    parameter int TIME_WIDTH = tte_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tte_pkg::THR_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [31:0]                   i_tap_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tte_pkg::STATUS_W-1:0]  o_status,
    output logic [tte_pkg::AVG_US_W-1:0]  o_avg_interval_us,
    output logic [tte_pkg::OUT_BPM_W-1:0] o_avg_bpm_x100,
    output logic [tte_pkg::OUT_BPM_W-1:0] o_last_bpm_x100
);
    import tte_pkg::*;

    // Sequencer
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uword;

    // Configuration and timing state
    logic [THR_W-1:0]      r_thr;
    logic [SUM_W-1:0]      r_sum;
    logic [COUNT_W-1:0]    r_count;
    logic [TIME_WIDTH-1:0] r_last;
    logic [SUM_W-1:0]      n_sum;
    logic [COUNT_W-1:0]    n_count;
    logic [TIME_WIDTH-1:0] n_last;

    // Item working registers
    logic                  r_cmd;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_diff;
    logic                  r_est;
    logic                  r_pos;
    logic [STATUS_W-1:0]   r_status;
    logic [AVG_US_W-1:0]   r_avg_us;
    logic [BPM_W-1:0]      r_avg_bpm;
    logic [BPM_W-1:0]      r_last_bpm;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [AVG_US_W-1:0] r_out_avg_us;
    logic [BPM_W-1:0]    r_out_avg_bpm;
    logic [BPM_W-1:0]    r_out_last_bpm;

    // Update combinational
    logic [TIME_WIDTH-1:0] diff;
    logic                  neg;
    logic                  gap;
    logic                  pos;
    logic                  add;
    logic                  est;
    logic [STATUS_W-1:0]   status;

    // Divider interface
    t_div_ctrl             div_ctrl;
    logic [DIV_REM_W-1:0]  div_rem_init;
    logic [DIV_NUM_W-1:0]  div_num_init;
    logic [DIV_REM_W-1:0]  div_divisor;
    logic                  div_last;
    logic [DIV_NUM_W-1:0]  div_quot;
    logic [PROD_US_W-1:0]  prod_us;
    logic [PROD_BPM_W-1:0] prod_bpm;

    logic in_xfer;
    logic out_free;

    assign uword      = ucode(r_step);
    assign o_in_ready = (uword.op == OP_ACCEPT);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Pick the next step
    always_comb begin
        case (uword.cond)
            C_NEXT:         n_step = r_step + 1'b1;
            C_GOTO:         n_step = uword.target;
            C_WAIT_IN:      n_step = i_in_valid ? r_step + 1'b1 : r_step;
            C_SKIP_NO_EST:  n_step = r_est ? r_step + 1'b1 : uword.target;
            C_SKIP_NO_LAST: n_step = (r_est && r_pos) ? r_step + 1'b1 : uword.target;
            C_LOOP_DIV:     n_step = div_last ? r_step + 1'b1 : r_step;
            C_WAIT_OUT:     n_step = out_free ? uword.target : r_step;
            default:        n_step = S_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

    // Interval, gap test and accumulation
    always_comb begin
        diff    = r_now - r_last;
        neg     = diff[TIME_WIDTH-1];
        gap     = !neg && (diff >= TIME_WIDTH'(r_thr));
        pos     = !neg && (diff != '0);
        add     = pos && !gap && (r_count != COUNT_MAX);
        n_sum   = r_sum;
        n_count = r_count;
        n_last  = r_now;
        if (r_cmd) begin
            n_sum   = '0;
            n_count = '0;
            n_last  = '0;
        end else if (gap) begin
            n_sum   = '0;
            n_count = '0;
        end else if (add) begin
            n_sum   = r_sum + SUM_W'(diff);
            n_count = r_count + 1'b1;
        end
        est = !r_cmd && (n_count != '0) && (n_sum != '0);
        if (r_cmd) begin
            status = ST_CLEARED;
        end else if (est) begin
            status = ST_EST;
        end else begin
            status = ST_NO_EST;
        end
    end

    // Configuration register and timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_sum   <= '0;
            r_count <= '0;
            r_last  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (uword.op == OP_UPDATE) begin
                r_sum   <= n_sum;
                r_count <= n_count;
                r_last  <= n_last;
            end
        end
    end

    // Scale the operands for the divider
    always_comb begin
        prod_us  = PROD_US_W'(r_sum) * PROD_US_W'(MS_PER_S);
        prod_bpm = PROD_BPM_W'(r_count) * PROD_BPM_W'(BPM_X100_NUM);
        div_ctrl.start = 1'b0;
        div_ctrl.step  = (uword.op == OP_DIV_STEP);
        div_ctrl.iters = ITERS_BPM;
        div_rem_init   = '0;
        div_num_init   = {BPM_X100_NUM, {(DIV_NUM_W-BPM_W){1'b0}}};
        div_divisor    = DIV_REM_W'(r_diff);
        case (uword.op)
            OP_LD_AVG_US: begin
                div_ctrl.start = 1'b1;
                div_ctrl.iters = ITERS_US;
                div_rem_init   = DIV_REM_W'(prod_us[PROD_US_W-1:DIV_NUM_W]);
                div_num_init   = prod_us[DIV_NUM_W-1:0];
                div_divisor    = DIV_REM_W'(r_count);
            end
            OP_LD_AVG_BPM: begin
                div_ctrl.start = 1'b1;
                div_rem_init   = DIV_REM_W'(prod_bpm[PROD_BPM_W-1:BPM_W]);
                div_num_init   = {prod_bpm[BPM_W-1:0], {(DIV_NUM_W-BPM_W){1'b0}}};
                div_divisor    = r_sum;
            end
            OP_LD_LAST: begin
                div_ctrl.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tte_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_rem_init (div_rem_init),
        .i_num_init (div_num_init),
        .i_divisor  (div_divisor),
        .o_last     (div_last),
        .o_quotient (div_quot)
    );

    // Item registers: capture, update flags, store quotients
    always_ff @(posedge i_clk) begin
        case (uword.op)
            OP_ACCEPT: begin
                if (in_xfer) begin
                    r_cmd <= i_cmd;
                    r_now <= i_tap_time[TIME_WIDTH-1:0];
                end
            end
            OP_UPDATE: begin
                r_diff     <= diff;
                r_est      <= est;
                r_pos      <= pos;
                r_status   <= status;
                r_avg_us   <= '0;
                r_avg_bpm  <= '0;
                r_last_bpm <= '0;
            end
            OP_ST_AVG_US:  r_avg_us   <= div_quot;
            OP_ST_AVG_BPM: r_avg_bpm  <= div_quot[BPM_W-1:0];
            OP_ST_LAST:    r_last_bpm <= div_quot[BPM_W-1:0];
            default: begin
            end
        endcase
    end

    // Output valid: set on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uword.op == OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (uword.op == OP_EMIT && out_free) begin
            r_out_status   <= r_status;
            r_out_avg_us   <= r_avg_us;
            r_out_avg_bpm  <= r_avg_bpm;
            r_out_last_bpm <= r_last_bpm;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_avg_interval_us = r_out_avg_us;
    assign o_avg_bpm_x100    = OUT_BPM_W'(r_out_avg_bpm);
    assign o_last_bpm_x100   = OUT_BPM_W'(r_out_last_bpm);

    // A new result only comes from the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_step == S_EMIT))
        else $error("output valid rose outside the emit step");

    // Every counted interval is at least one millisecond
    a_sum_ge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_sum >= SUM_W'(r_count))
        else $error("interval sum below interval count");

    // Divisions run only for an item with an estimate
    a_div_needs_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_DIV_US || r_step == S_DIV_BPM) |-> r_est)
        else $error("division started without an estimate");

    // Last-interval division needs a positive interval
    a_last_needs_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == S_DIV_LAST |-> (r_est && r_pos && r_diff != '0))
        else $error("last tempo division without a positive interval");

    // Values are zero unless an estimate is reported
    a_zero_no_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_EST) |->
        (o_avg_interval_us == '0 && o_avg_bpm_x100 == '0 && o_last_bpm_x100 == '0))
        else $error("non-zero value with no estimate");

endmodule

// ===== sim/tap_tempo_estimator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tap_tempo_estimator: directed and random tap streams,
// a running prediction of every result, and random idling on both channels.
// Depends on tte_pkg and the tap_tempo_estimator RTL.

module tap_tempo_estimator_tb;
    import tte_pkg::*;

    localparam int          CYCLE_LIMIT = 20_000_000;
    localparam int          TAIL_CYCLES = 200;
    localparam int          RAND_PHASES = 6;
    localparam int          PHASE_ITEMS = 175;
    localparam logic        CMD_TAP     = 1'b0;
    localparam logic        CMD_CLEAR   = 1'b1;
    localparam longint unsigned US_PER_MS = 1000;
    localparam longint unsigned BPM_SCALE = 6000000;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [AVG_US_W-1:0]  avg_us;
        logic [OUT_BPM_W-1:0] avg_bpm;
        logic [OUT_BPM_W-1:0] last_bpm;
    } t_tempo_reading;

    // Tracks the tap timing state and holds the readings still to come
    class tempo_scoreboard;
        bit [THR_W-1:0]   gap_limit  = THR_RESET;
        bit [SUM_W-1:0]   beat_sum   = '0;
        bit [COUNT_W-1:0] beat_count = '0;
        bit [31:0]        prev_tap   = '0;
        t_tempo_reading   pending_readings[$];
        int               errors     = 0;

        function void set_gap_limit(bit [THR_W-1:0] v);
            gap_limit = v;
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        // Advance the timing state by one transfer and queue its reading
        function void log_tap(bit clear_cmd, bit [31:0] tap);
            bit [31:0]      gap;
            bit             gap_neg;
            bit             gap_pos;
            bit [63:0]      wide;
            t_tempo_reading r;
            r = '0;
            if (clear_cmd) begin
                beat_sum   = '0;
                beat_count = '0;
                prev_tap   = '0;
                r.status   = ST_CLEARED;
            end else begin
                gap      = tap - prev_tap;
                gap_neg  = gap[31];
                gap_pos  = !gap_neg && (gap != 0);
                r.status = ST_NO_EST;
                if (!gap_neg && gap >= gap_limit) begin
                    beat_sum   = '0;
                    beat_count = '0;
                end else if (gap_pos && beat_count != COUNT_MAX) begin
                    beat_sum   = beat_sum + gap;
                    beat_count = beat_count + 1'b1;
                end
                if (beat_count != 0 && beat_sum != 0) begin
                    r.status  = ST_EST;
                    wide      = (64'(beat_sum) * US_PER_MS) / 64'(beat_count);
                    r.avg_us  = wide[AVG_US_W-1:0];
                    wide      = (64'(beat_count) * BPM_SCALE) / 64'(beat_sum);
                    r.avg_bpm = wide[OUT_BPM_W-1:0];
                    if (gap_pos) begin
                        wide       = BPM_SCALE / 64'(gap);
                        r.last_bpm = wide[OUT_BPM_W-1:0];
                    end
                end
                prev_tap = tap;
            end
            pending_readings.push_back(r);
        endfunction

        // Compare one transfer on the result channel with the oldest reading
        function void check_reading(t_tempo_reading got);
            t_tempo_reading want;
            if (pending_readings.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with none outstanding: status %0d", $time,
                             got.status);
            end else begin
                want = pending_readings.pop_front();
                if (got.status !== want.status || got.avg_us !== want.avg_us ||
                    got.avg_bpm !== want.avg_bpm || got.last_bpm !== want.last_bpm) begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: mismatch status %0d/%0d avg_us %0d/%0d ",
                                  "avg_bpm %0d/%0d last_bpm %0d/%0d (expected/actual)"},
                                 $time, want.status, got.status, want.avg_us, got.avg_us,
                                 want.avg_bpm, got.avg_bpm, want.last_bpm, got.last_bpm);
                end
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [THR_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd      = 1'b0;
    logic [31:0]           i_tap_time = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [AVG_US_W-1:0]   o_avg_interval_us;
    logic [OUT_BPM_W-1:0]  o_avg_bpm_x100;
    logic [OUT_BPM_W-1:0]  o_last_bpm_x100;

    tempo_scoreboard sb = new();
    bit              idle_en   = 1'b0;
    int              stall_left = 0;
    longint          cycle_count = 0;
    bit [31:0]       tap_clock = '0;
    bit [THR_W-1:0]  cur_limit = THR_RESET;

    tap_tempo_estimator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_tap_time        (i_tap_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_avg_interval_us (o_avg_interval_us),
        .o_avg_bpm_x100    (o_avg_bpm_x100),
        .o_last_bpm_x100   (o_last_bpm_x100)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tap_tempo_estimator_tb: errors");
        $finish;
    end

    // Stall the result channel at random while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check every transfer on the result channel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_reading('{o_status, o_avg_interval_us, o_avg_bpm_x100, o_last_bpm_x100});
    end

    // Present one item, with an optional gap first, and hold it until the transfer
    task automatic send_item(input logic cmd, input logic [31:0] tap);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_tap_time <= tap;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.log_tap(cmd, tap);
    endtask

    task automatic tap_at(input logic [31:0] tap);
        tap_clock = tap;
        send_item(CMD_TAP, tap);
    endtask

    // Drop valid and hold off until every outstanding reading has arrived
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [THR_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_gap_limit(v);
        cur_limit = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly human-rate taps, with clears, repeats, backward steps, long gaps and noise
    task automatic random_taps(input int n, input bit allow_idle);
        int          kind;
        int unsigned span;
        for (int i = 0; i < n; i++) begin
            if (allow_idle && i % 40 == 0 && n > 0)
                idle_en = idle_en ? ($urandom_range(0, 2) != 0) : 1'b1;
            kind = $urandom_range(0, 99);
            span = (cur_limit > 1) ? 32'(cur_limit - 1'b1) : 32'd1;
            if (kind < 4) begin
                send_item(CMD_CLEAR, $urandom());
                tap_clock = $urandom_range(0, 1) ? '0 : tap_clock;
            end else if (kind < 8) begin
                tap_at($urandom());
            end else if (kind < 12) begin
                tap_at(tap_clock);
            end else if (kind < 17) begin
                tap_at(tap_clock - $urandom_range(1, 1 << 20));
            end else if (kind < 22) begin
                tap_at(tap_clock + cur_limit + $urandom_range(0, 70000));
            end else begin
                tap_at(tap_clock + $urandom_range(1, span));
            end
            if ($urandom_range(0, 49) == 0)
                drain();
        end
    endtask

    initial begin
        logic [THR_W-1:0] limits [RAND_PHASES];

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default limit of 5000 ms
        idle_en = 1'b1;
        tap_at(32'd100);                      // first tap measured from zero
        tap_at(32'd100);                      // zero interval
        tap_at(32'd50);                       // backward step
        tap_at(32'd600);
        tap_at(32'd5600);                     // gap exactly at the limit
        tap_at(32'd10599);                    // gap just under the limit
        send_item(CMD_CLEAR, 32'hFFFF_FFFF);
        tap_at(32'hFFFF_FFFF);                // negative against zero after clear
        tap_at(32'd4);                        // timestamp wraps
        tap_at(32'h8000_0004);                // most negative interval
        tap_at(32'd0);                        // positive interval of 0x7FFFFFFC
        send_item(CMD_CLEAR, 32'd0);
        tap_at(32'd0);

        // Directed: widest limit, longest averages and fastest tempo
        write_limit(16'hFFFF);
        tap_at(32'd65534);
        tap_at(32'd131068);
        tap_at(32'd196603);
        tap_at(32'd196604);

        // Directed: zero limit clears on any forward or repeated tap
        write_limit(16'd0);
        tap_at(32'd196604);
        tap_at(32'd196603);
        tap_at(32'd196700);
        write_limit(16'd1);
        tap_at(32'd196701);

        limits[0] = 16'hFFFF;
        limits[1] = 16'd0;
        limits[2] = 16'd1;
        limits[3] = 16'd600;
        limits[4] = 16'($urandom_range(2, 65535));
        limits[5] = 16'd5000;
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_limit(limits[p]);
            idle_en = 1'b1;
            if (p == RAND_PHASES - 1)
                idle_en = 1'b0;
            random_taps(PHASE_ITEMS, p != RAND_PHASES - 1);
            if (p == RAND_PHASES - 1)
                idle_en = 1'b0;
        end

        // Let the last readings arrive, then watch for strays
        drain();
        idle_en = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tap_tempo_estimator_tb: clean");
        else
            $display("tap_tempo_estimator_tb: errors");
        $finish;
    end

endmodule
